// ===== design/lsfp_pkg.sv =====
package lsfp_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned CH_IDX_W = 4;   // holds 0..CHANNELS

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'd2000;

  typedef enum logic {
    PH_WAIT,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIG,
    KIND_ANA,
    KIND_OTHER
  } kind_e;

  // analog channel token: x, channel number, colon, digits
  typedef enum logic [1:0] {
    MS_X,
    MS_NUM,
    MS_COLON,
    MS_DIGITS
  } match_e;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic                 frame_kind;
    logic                 frame_ok;
    logic [CHANNELS-1:0]  raw_mask;
    level_t [CHANNELS-1:0] levels;
  } result_t;

endpackage

// ===== design/line_sensor_frame_parser_top.sv =====
// The byte or timeout that ends the body yields a result registered into the m_axis output
// register (or skid entry). One item per cycle while the skid entry is empty; the parser
// updates all state in a single registered pass. A two-entry output buffer keeps the input
// running while one result is stalled. Reset (rst_ni low, asynchronous): parser waits for '$',
// stored levels and raw bits clear to zero, threshold returns to 2000, output buffer empties.
module line_sensor_frame_parser_top #(
  parameter int unsigned MAX_BODY = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,       // analog_threshold
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,     // rx_byte
  input  logic [0:0]   s_axis_tuser,     // timeout
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,     // frame_ok, raw_mask, channel_1..8_level, zero pad
  output logic [0:0]   m_axis_tuser      // frame_kind
);
  import lsfp_pkg::*;

  localparam int unsigned DATA_BITS = 1 + CHANNELS + CHANNELS * LEVEL_W;

  level_t  thr_q;
  logic    req;
  logic    res_valid;
  result_t res;

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_vld_q;
  assign req           = s_axis_tvalid && s_axis_tready;
  assign pop           = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  lsfp_parser #(
    .MAX_BODY (MAX_BODY)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .timeout_i   (s_axis_tuser[0]),
    .byte_i      (s_axis_tdata),
    .threshold_i (thr_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // a new result only arrives while the skid entry is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        out_vld_q  <= skid_vld_q || res_valid;
        skid_vld_q <= 1'b0;
      end else if (res_valid) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= out_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (res_valid && !out_vld_q) begin
      out_q <= res;
    end
    if (res_valid && out_vld_q && !pop) begin
      skid_q <= res;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0] = out_q.frame_ok;
    m_axis_tdata[CHANNELS:1] = out_q.raw_mask;
    for (int i = 0; i < CHANNELS; i++) begin
      m_axis_tdata[1 + CHANNELS + i*LEVEL_W +: LEVEL_W] = out_q.levels[i];
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tuser[0] = out_q.frame_kind;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !m_axis_tready |=> skid_vld_q)
    else $error("buffered result dropped without a pop");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && out_vld_q && !m_axis_tready |=> skid_vld_q && !s_axis_tready)
    else $error("stalled result not held in skid entry");

  a_data_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[143:DATA_BITS] == '0)
    else $error("padding bits of result data not zero");

endmodule

// ===== design/lsfp_parser.sv =====
module lsfp_parser #(
  parameter int unsigned MAX_BODY = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,        // one item accepted this cycle
  input  logic                      timeout_i,
  input  logic [7:0]                byte_i,
  input  lsfp_pkg::level_t          threshold_i,
  output logic                      res_valid_o,
  output lsfp_pkg::result_t         res_o
);
  import lsfp_pkg::*;

  localparam int unsigned LW = $clog2(MAX_BODY);
  localparam logic [LW-1:0] LAST_LEN = LW'(MAX_BODY - 1);
  localparam logic [CH_IDX_W-1:0] CH_END  = CH_IDX_W'(CHANNELS);
  localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNELS - 1);

  phase_e                phase_q, phase_d;
  logic [LW-1:0]         len_q, len_d;
  kind_e                 kind_q, kind_d;
  logic [CH_IDX_W-1:0]   ch_q, ch_d;
  match_e                ms_q, ms_d;
  level_t                acc_q, acc_d;
  logic                  dp_q, dp_d;
  logic                  fail_q, fail_d;
  level_t [CHANNELS-1:0] pend_q, pend_d;
  level_t [CHANNELS-1:0] lvl_q, lvl_d;
  logic [CHANNELS-1:0]   raw_q, raw_d;

  logic                  ending;
  logic                  ok;
  logic                  is_digit;
  logic [3:0]            digit;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = byte_i[3:0];   // low nibble of an ASCII digit

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    kind_d      = kind_q;
    ch_d        = ch_q;
    ms_d        = ms_q;
    acc_d       = acc_q;
    dp_d        = dp_q;
    fail_d      = fail_q;
    pend_d      = pend_q;
    lvl_d       = lvl_q;
    raw_d       = raw_q;
    ending      = 1'b0;
    ok          = 1'b0;
    res_valid_o = 1'b0;

    if (req_i) begin
      if (phase_q == PH_WAIT) begin
        if (!timeout_i && byte_i == CH_DOLLAR) begin
          phase_d = PH_BODY;
          len_d   = '0;
          kind_d  = KIND_NONE;
          ch_d    = '0;
          ms_d    = MS_X;
          acc_d   = '0;
          dp_d    = 1'b0;
          fail_d  = 1'b0;
        end
      end else if (timeout_i || byte_i == CH_HASH) begin
        ending = 1'b1;
      end else begin
        if (len_q == '0) begin
          kind_d = (byte_i == CH_D) ? KIND_DIG : (byte_i == CH_A) ? KIND_ANA : KIND_OTHER;
        end else if (len_q == LW'(1)) begin
          if (byte_i != CH_COMMA) fail_d = 1'b1;
        end else if (!fail_q && ch_q < CH_END) begin
          if (kind_q == KIND_DIG) begin
            if (ms_q == MS_X) begin
              // digital bodies reuse the first step as "waiting for colon"
              if (byte_i == CH_COLON) ms_d = MS_NUM;
            end else begin
              raw_d[ch_q[2:0]] = (byte_i != CH_ZERO);
              ch_d = ch_q + CH_IDX_W'(1);
              ms_d = MS_X;
            end
          end else if (kind_q == KIND_ANA) begin
            unique case (ms_q)
              MS_X: begin
                if (byte_i == CH_X) ms_d = MS_NUM;
                else fail_d = 1'b1;
              end
              MS_NUM: begin
                if (byte_i == CH_ONE + {4'b0, ch_q}) ms_d = MS_COLON;
                else fail_d = 1'b1;
              end
              MS_COLON: begin
                if (byte_i == CH_COLON) begin
                  ms_d  = MS_DIGITS;
                  acc_d = '0;
                  dp_d  = 1'b0;
                end else begin
                  fail_d = 1'b1;
                end
              end
              MS_DIGITS: begin
                if (is_digit) begin
                  // acc*10 + digit, wraps at 16 bits
                  acc_d = LEVEL_W'({acc_q, 3'b000} + {acc_q, 1'b0} + {12'b0, digit});
                  dp_d  = 1'b1;
                end else if (!dp_q) begin
                  fail_d = 1'b1;
                end else begin
                  pend_d[ch_q[2:0]] = acc_q;
                  if (ch_q == CH_LAST) begin
                    ch_d = CH_END;
                  end else if (byte_i == CH_COMMA) begin
                    ch_d = ch_q + CH_IDX_W'(1);
                    ms_d = MS_X;
                  end else begin
                    fail_d = 1'b1;
                  end
                end
              end
              default: fail_d = 1'b1;
            endcase
          end
        end
        len_d = len_q + LW'(1);
        if (len_d >= LAST_LEN) ending = 1'b1;
      end

      if (ending) begin
        phase_d = PH_WAIT;
        if (len_d != '0) begin
          res_valid_o = 1'b1;
          if (kind_d == KIND_DIG) begin
            ok = !fail_d && (len_d >= LW'(2)) && (ch_d >= CH_END);
          end else if (kind_d == KIND_ANA && !fail_d && len_d >= LW'(2)) begin
            // last value may end with the body itself
            if (ch_d == CH_LAST && ms_d == MS_DIGITS && dp_d) begin
              pend_d[CHANNELS-1] = acc_d;
              ch_d = CH_END;
            end
            if (ch_d >= CH_END) begin
              ok    = 1'b1;
              lvl_d = pend_d;
              for (int i = 0; i < CHANNELS; i++) begin
                raw_d[i] = pend_d[i] > threshold_i;
              end
            end
          end
        end
      end
    end

    res_o.frame_kind = (kind_d == KIND_ANA);
    res_o.frame_ok   = ok;
    res_o.raw_mask   = raw_d;
    res_o.levels     = lvl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      len_q   <= '0;
      kind_q  <= KIND_NONE;
      ch_q    <= '0;
      ms_q    <= MS_X;
      acc_q   <= '0;
      dp_q    <= 1'b0;
      fail_q  <= 1'b0;
      lvl_q   <= '0;
      raw_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      kind_q  <= kind_d;
      ch_q    <= ch_d;
      ms_q    <= ms_d;
      acc_q   <= acc_d;
      dp_q    <= dp_d;
      fail_q  <= fail_d;
      lvl_q   <= lvl_d;
      raw_q   <= raw_d;
    end
  end

  // written in every analog body before being read
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule
